// File: sv/pale_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pale_pkg
// Shared types and constants of the positional array list engine: store
// geometry, request and status codes, and the item structs of both channels.
// ----------------------------------------------------------------------------
package pale_pkg;

  // store geometry
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } pale_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         found_index;
    logic signed [DATA_W-1:0] out_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     last;
  } pale_out_t;

  // store access from the sequencer
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [ADDR_W-1:0]        raddr;
  } pale_ram_req_t;

endpackage
`default_nettype wire

// File: sv/pale_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pale_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module pale_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/pale_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pale_ctrl
// Request sequencer: holds the live count, walks the store through the RAM
// ports to shift, search and dump, and hands each result to the output stage.
// ----------------------------------------------------------------------------
module pale_ctrl (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     req_valid,
  output      logic                                     req_ready,
  input  wire pale_pkg::pale_in_t                       req,
  output      logic                                     res_valid,
  input  wire logic                                     res_ready,
  output      pale_pkg::pale_out_t                      res,
  output      pale_pkg::pale_ram_req_t                  ram_req,
  input  wire logic signed [pale_pkg::DATA_W-1:0]       ram_rdata
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SHIFT     = 7'b0000010,
    S_INS_WR    = 7'b0000100,
    S_SRCH      = 7'b0001000,
    S_DUMP_RD   = 7'b0010000,
    S_DUMP_EMIT = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [pale_pkg::CNT_W-1:0]            count_r, count_nxt;
  logic [pale_pkg::CNT_W-1:0]            rem_r, rem_nxt;
  logic [pale_pkg::ADDR_W-1:0]           src_r, src_nxt;
  logic [pale_pkg::ADDR_W-1:0]           dst_r, dst_nxt;
  logic                                  pend_r, pend_nxt;
  logic                                  ins_r, ins_nxt;
  logic [pale_pkg::ADDR_W-1:0]           pos_r, pos_nxt;
  logic signed [pale_pkg::DATA_W-1:0]    val_r, val_nxt;
  logic [pale_pkg::STAT_W-1:0]           stat_r, stat_nxt;
  logic [pale_pkg::IDX_W-1:0]            fidx_r, fidx_nxt;

  logic [pale_pkg::POS_W-1:0]            count_pos;
  logic                                  full;
  logic                                  hit;

  assign count_pos = pale_pkg::POS_W'(count_r);
  assign full      = (count_r >= pale_pkg::CNT_W'(pale_pkg::CAPACITY));
  assign hit       = pend_r && (ram_rdata == val_r);
  assign req_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    pend_nxt  = pend_r;
    ins_nxt   = ins_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    stat_nxt  = stat_r;
    fidx_nxt  = fidx_r;
    ram_req   = '0;
    res_valid = 1'b0;
    res       = '0;
    res.entry_count = pale_pkg::COUNT_W'(count_r);

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          pos_nxt  = pale_pkg::ADDR_W'(req.position);
          val_nxt  = req.item_value;
          pend_nxt = 1'b0;
          fidx_nxt = '0;
          unique case (req.req_type)
            pale_pkg::REQ_INSERT: begin
              if (req.position > count_pos) begin
                stat_nxt  = pale_pkg::ST_BADPOS;
                state_nxt = S_RESP;
              end else if (full) begin
                stat_nxt  = pale_pkg::ST_FULL;
                state_nxt = S_RESP;
              end else begin
                // move entries pos..n-1 up, from the top down
                ins_nxt   = 1'b1;
                rem_nxt   = pale_pkg::CNT_W'(count_pos - req.position);
                src_nxt   = pale_pkg::ADDR_W'(count_r - pale_pkg::CNT_W'(1));
                count_nxt = count_r + pale_pkg::CNT_W'(1);
                stat_nxt  = pale_pkg::ST_OK;
                state_nxt = S_SHIFT;
              end
            end
            pale_pkg::REQ_DELETE: begin
              if (count_r == '0) begin
                stat_nxt  = pale_pkg::ST_EMPTY;
                state_nxt = S_RESP;
              end else if (req.position >= count_pos) begin
                stat_nxt  = pale_pkg::ST_BADPOS;
                state_nxt = S_RESP;
              end else begin
                // move entries pos+1..n-1 down, from the bottom up
                ins_nxt   = 1'b0;
                rem_nxt   = pale_pkg::CNT_W'(count_pos - req.position - 1'b1);
                src_nxt   = pale_pkg::ADDR_W'(req.position + 1'b1);
                count_nxt = count_r - pale_pkg::CNT_W'(1);
                stat_nxt  = pale_pkg::ST_OK;
                state_nxt = S_SHIFT;
              end
            end
            pale_pkg::REQ_SEARCH: begin
              stat_nxt = pale_pkg::ST_NOTFOUND;
              if (count_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                rem_nxt   = count_r;
                src_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            pale_pkg::REQ_DUMP: begin
              if (count_r == '0) begin
                stat_nxt  = pale_pkg::ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                rem_nxt   = count_r;
                src_nxt   = '0;
                state_nxt = S_DUMP_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // read one entry ahead, write the previous read to its new place
      S_SHIFT: begin
        ram_req.we    = pend_r;
        ram_req.waddr = dst_r;
        ram_req.wdata = ram_rdata;
        if (rem_r != '0) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = src_r;
          pend_nxt      = 1'b1;
          dst_nxt       = ins_r ? src_r + 1'b1 : src_r - 1'b1;
          src_nxt       = ins_r ? src_r - 1'b1 : src_r + 1'b1;
          rem_nxt       = rem_r - pale_pkg::CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ins_r ? S_INS_WR : S_RESP;
        end
      end

      // drop the new value into the opened slot
      S_INS_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = val_r;
        state_nxt     = S_RESP;
      end

      // streaming compare, one entry per cycle
      S_SRCH: begin
        if (hit) begin
          stat_nxt  = pale_pkg::ST_OK;
          fidx_nxt  = pale_pkg::IDX_W'(dst_r);
          state_nxt = S_RESP;
        end else if (rem_r != '0) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = src_r;
          pend_nxt      = 1'b1;
          dst_nxt       = src_r;
          src_nxt       = src_r + 1'b1;
          rem_nxt       = rem_r - pale_pkg::CNT_W'(1);
        end else begin
          stat_nxt  = pale_pkg::ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end

      S_DUMP_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = src_r;
        state_nxt     = S_DUMP_EMIT;
      end

      // one dump item per entry, held until the output stage takes it
      S_DUMP_EMIT: begin
        res_valid       = 1'b1;
        res.status      = pale_pkg::ST_OK;
        res.found_index = pale_pkg::IDX_W'(src_r);
        res.out_value   = ram_rdata;
        res.last        = (rem_r == pale_pkg::CNT_W'(1));
        if (res_ready) begin
          src_nxt   = src_r + 1'b1;
          rem_nxt   = rem_r - pale_pkg::CNT_W'(1);
          state_nxt = res.last ? S_IDLE : S_DUMP_RD;
        end
      end

      S_RESP: begin
        res_valid       = 1'b1;
        res.status      = stat_r;
        res.found_index = fidx_r;
        res.last        = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // walk and request payload
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    ins_r  <= ins_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    stat_r <= stat_nxt;
    fidx_r <= fidx_nxt;
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pale_pkg::CNT_W'(pale_pkg::CAPACITY))
    else $error("live count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("read and write hit the same entry in one cycle");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!res_valid && !ram_req.we))
    else $error("activity while idle");

  a_dump_next: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && !res.last) |=> (state_r == S_DUMP_RD))
    else $error("dump did not continue after a non-final item");

  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (count_r == $past(count_r)))
    else $error("live count changed during a walk");
`endif

endmodule
`default_nettype wire

// File: sv/positional_array_list_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_engine_unit
// Array list of signed 32-bit values with insert, delete, search and dump.
// ----------------------------------------------------------------------------
// One request is handled at a time; every entry move or compare goes through
// the single read and single write port of the entry RAM, one entry per
// cycle. A dump reads each entry, then hands it over to the output stage.
// Results pass through an output register, so the next request is taken
// while the last result still waits on out_ready. No clearing pass is
// needed after reset: only entries below the live count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list_engine_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire pale_pkg::pale_in_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      pale_pkg::pale_out_t out_data
);

  pale_pkg::pale_ram_req_t             ram_req;
  logic signed [pale_pkg::DATA_W-1:0]  ram_rdata;
  logic                                res_valid;
  logic                                res_ready;
  pale_pkg::pale_out_t                 res;
  logic                                out_valid_r, out_valid_nxt;
  pale_pkg::pale_out_t                 out_data_r;

  pale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  pale_ram #(
    .DEPTH (pale_pkg::CAPACITY),
    .WIDTH (pale_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register: loads when empty or draining
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sim/pale_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pale_list_checker
// Watches both channels of the array list engine. Each accepted request is
// run through a local copy of the list to predict its results, and each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pale_list_checker
  import pale_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  pale_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  pale_out_t out_data,
  output int        mismatch_count,
  output int        awaited,
  output int        requests_seen,
  output int        results_seen,
  output int        peak_length
);

  // local copy of the list
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_len;

  // predicted results not yet seen on the output
  pale_out_t due_results [$];
  int        reported;

  function automatic pale_out_t make_result(input logic [STAT_W-1:0] st, input int idx,
                                            input logic signed [DATA_W-1:0] val,
                                            input logic lst);
    pale_out_t r;
    r.status      = st;
    r.found_index = idx[IDX_W-1:0];
    r.out_value   = val;
    r.entry_count = shadow_len[COUNT_W-1:0];
    r.last        = lst;
    return r;
  endfunction

  // update the list and queue up the results of one request
  task automatic apply_request(input pale_in_t req);
    int pos;
    int i;
    int hit;
    pos = int'(req.position);
    case (req.req_type)
      REQ_INSERT: begin
        if (pos > shadow_len) begin
          due_results.push_back(make_result(ST_BADPOS, 0, '0, 1'b1));
        end else if (shadow_len >= CAPACITY) begin
          due_results.push_back(make_result(ST_FULL, 0, '0, 1'b1));
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = req.item_value;
          shadow_len++;
          due_results.push_back(make_result(ST_OK, 0, '0, 1'b1));
        end
      end
      REQ_DELETE: begin
        if (shadow_len == 0) begin
          due_results.push_back(make_result(ST_EMPTY, 0, '0, 1'b1));
        end else if (pos >= shadow_len) begin
          due_results.push_back(make_result(ST_BADPOS, 0, '0, 1'b1));
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
          due_results.push_back(make_result(ST_OK, 0, '0, 1'b1));
        end
      end
      REQ_SEARCH: begin
        // lowest index wins when a value appears more than once
        hit = -1;
        for (i = 0; i < shadow_len && hit < 0; i++) begin
          if (shadow_entries[i] == req.item_value) hit = i;
        end
        if (hit >= 0) due_results.push_back(make_result(ST_OK, hit, '0, 1'b1));
        else due_results.push_back(make_result(ST_NOTFOUND, 0, '0, 1'b1));
      end
      default: begin
        if (shadow_len == 0) begin
          due_results.push_back(make_result(ST_EMPTY, 0, '0, 1'b1));
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            due_results.push_back(make_result(ST_OK, i, shadow_entries[i],
                                              i == shadow_len - 1));
          end
        end
      end
    endcase
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin : watch_channels
    pale_out_t want;
    logic      bad;
    if (!rst_n) begin
      due_results.delete();
      shadow_len = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
        requests_seen++;
        if (shadow_len > peak_length) peak_length = shadow_len;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (reported < 10) begin
            $display("%0t: unexpected result st=%0d idx=%0d val=%0d cnt=%0d last=%0b",
                     $realtime, out_data.status, out_data.found_index,
                     out_data.out_value, out_data.entry_count, out_data.last);
            reported++;
          end
        end else begin
          want = due_results.pop_front();
          bad  = (out_data.status !== want.status) ||
                 (out_data.found_index !== want.found_index) ||
                 (out_data.out_value !== want.out_value) ||
                 (out_data.entry_count !== want.entry_count) ||
                 (out_data.last !== want.last);
          if (bad) begin
            mismatch_count++;
            if (reported < 10) begin
              $display("%0t: result %0d mismatch", $realtime, results_seen);
              $display("  want st=%0d idx=%0d val=%0d cnt=%0d last=%0b",
                       want.status, want.found_index, want.out_value,
                       want.entry_count, want.last);
              $display("  got  st=%0d idx=%0d val=%0d cnt=%0d last=%0b",
                       out_data.status, out_data.found_index, out_data.out_value,
                       out_data.entry_count, out_data.last);
              reported++;
            end
          end
        end
      end
    end
    awaited <= due_results.size();
  end

endmodule

// File: sim/positional_array_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_engine_unit_tb
// Drives the array list engine with a directed opening (empty list, bad
// positions, extreme values, duplicate search, dumps) and then random
// grow and shrink phases that fill the store to capacity and drain it,
// with bursty requests and a stalling result side. A checker module does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module positional_array_list_engine_unit_tb;
  import pale_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;
  localparam int TOTAL_ITEMS = 210;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  pale_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  pale_out_t out_data;

  int mismatch_count;
  int awaited;
  int requests_seen;
  int results_seen;
  int peak_length;

  // stimulus-side bookkeeping
  int                       list_len;
  int                       burst_left;
  int                       n_sent;
  int                       idle_cycles;
  int                       rdy_left;
  int                       rdy_mode;
  logic signed [DATA_W-1:0] value_pool [16];

  positional_array_list_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pale_list_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .awaited        (awaited),
    .requests_seen  (requests_seen),
    .results_seen   (results_seen),
    .peak_length    (peak_length)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side stalls: runs of always ready, coin flips, or mostly stalled
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 2);
      rdy_left <= $urandom_range(8, 60);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results awaited",
               idle_cycles, awaited);
      $display("FAIL");
      $finish;
    end
  end

  // half from a small pool so searches hit and duplicates appear
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 1) return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // send one request in bursts with random gaps between them
  task automatic issue(input logic [REQ_W-1:0] req, input int pos,
                       input logic signed [DATA_W-1:0] val);
    pale_in_t it;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.req_type   = req;
    it.position   = pos[POS_W-1:0];
    it.item_value = val;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    // track the length only to aim positions
    case (req)
      REQ_INSERT: if (pos <= list_len && list_len < CAPACITY) list_len++;
      REQ_DELETE: if (list_len > 0 && pos < list_len) list_len--;
      default: ;
    endcase
  endtask

  task automatic insert_valid();
    issue(REQ_INSERT, $urandom_range(0, list_len), pick_value());
  endtask

  task automatic delete_valid();
    issue(REQ_DELETE, (list_len > 0) ? $urandom_range(0, list_len - 1) : 0, pick_value());
  endtask

  // main sequence
  initial begin : stimulus
    logic grow;
    int   roll;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    rdy_left   = 0;
    rdy_mode   = 0;
    list_len   = 0;
    burst_left = 0;
    n_sent     = 0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int k = 4; k < 16; k++) value_pool[k] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners
    issue(REQ_DUMP,   0,        32'sd0);
    issue(REQ_DELETE, 0,        32'sd0);
    issue(REQ_DELETE, CAPACITY, 32'sd0);
    issue(REQ_SEARCH, 0,        32'sd0);
    issue(REQ_INSERT, 1,        32'sd5);
    issue(REQ_INSERT, CAPACITY, 32'sd5);
    // build a short list with extreme values and a duplicate
    issue(REQ_INSERT, 0, 32'sh7FFF_FFFF);
    issue(REQ_INSERT, 0, 32'sh8000_0000);
    issue(REQ_INSERT, 2, -32'sd1);
    issue(REQ_INSERT, 1, 32'sd0);
    issue(REQ_INSERT, 1, 32'sd0);
    issue(REQ_SEARCH, 63, 32'sd0);
    issue(REQ_SEARCH, 0,  -32'sd1);
    issue(REQ_SEARCH, 0,  32'sh8000_0000);
    issue(REQ_SEARCH, 0,  32'sd12345);
    issue(REQ_DUMP,   0,  32'sd0);
    // delete past the end, then at the tail, the head and the middle
    issue(REQ_DELETE, 5,        32'sd0);
    issue(REQ_DELETE, CAPACITY, 32'sd0);
    issue(REQ_DELETE, 4,        32'sd0);
    issue(REQ_DELETE, 0,        32'sd0);
    issue(REQ_DELETE, 1,        32'sd0);
    issue(REQ_DUMP,   0,        32'sd0);
    issue(REQ_SEARCH, 0,        32'sh7FFF_FFFF);

    // random grow and shrink phases
    grow = 1'b1;
    while (n_sent < TOTAL_ITEMS) begin
      if (grow && list_len == CAPACITY) begin
        // full store: every valid position is refused
        issue(REQ_INSERT, 0, pick_value());
        issue(REQ_INSERT, CAPACITY, pick_value());
        issue(REQ_INSERT, $urandom_range(1, CAPACITY - 1), pick_value());
        issue(REQ_DUMP, $urandom_range(0, CAPACITY), pick_value());
        grow = 1'b0;
      end else if (!grow && list_len == 0) begin
        issue(REQ_DELETE, $urandom_range(0, CAPACITY), pick_value());
        issue(REQ_DUMP, $urandom_range(0, CAPACITY), pick_value());
        issue(REQ_SEARCH, $urandom_range(0, CAPACITY), pick_value());
        grow = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          if (grow) insert_valid(); else delete_valid();
        end else if (roll < 76) begin
          if (grow) delete_valid(); else insert_valid();
        end else if (roll < 80) begin
          issue(REQ_INSERT,
                (list_len < CAPACITY) ? $urandom_range(list_len + 1, CAPACITY) : CAPACITY,
                pick_value());
        end else if (roll < 84) begin
          issue(REQ_DELETE, $urandom_range(list_len, CAPACITY), pick_value());
        end else if (roll < 96) begin
          issue(REQ_SEARCH, $urandom_range(0, CAPACITY), pick_value());
        end else begin
          issue(REQ_DUMP, $urandom_range(0, CAPACITY), pick_value());
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then give late results a chance to show
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results, list length up to %0d of %0d",
             requests_seen, results_seen, peak_length, CAPACITY);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
